>>> sv/point_cloud_to_polar_min_range_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef POINT_CLOUD_TO_POLAR_MIN_RANGE_UNIT_MACROS_SVH
`define POINT_CLOUD_TO_POLAR_MIN_RANGE_UNIT_MACROS_SVH

// A property checked at every clock edge outside reset.
`define PCPMR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define PCPMR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

>>> sv/pcpmr_pkg.sv
package pcpmr_pkg;

    localparam int NUM_BINS     = 720;
    localparam int BIN_W        = $clog2(NUM_BINS);
    localparam int RANGE_W      = 18;
    localparam int COORD_W      = 18;
    localparam int ROT_W        = 20;
    localparam int SQ_W         = 38;
    localparam int ROOT_W       = SQ_W / 2;
    localparam int REM_W        = ROOT_W + 2;
    localparam int CX_W         = 44;
    localparam int ANG_W        = 32;
    localparam int CORDIC_STEPS = 16;
    localparam int SQRT_STEPS   = ROOT_W;
    localparam int CNT_W        = 5;
    localparam int MUL_A_W      = 33;
    localparam int MUL_B_W      = 20;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_W        = 16;

    localparam logic [RANGE_W-1:0] EMPTY_RANGE = 18'h3FFFF;
    localparam logic [RANGE_W-1:0] MAX_RANGE   = 18'h3FFFE;

    localparam logic [CFG_IDX_W-1:0] CFG_COS_TILT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_TILT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOUNT_HEIGHT = 2'd2;

    localparam logic CMD_POINT = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef struct packed {
        logic load;
        logic step;
    } vec_ctrl_t;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [ANG_W-1:0] atan_turn(input logic [3:0] i);
        logic [ANG_W-1:0] v;
        case (i)
            4'd0:    v = 32'd536870912;
            4'd1:    v = 32'd316933406;
            4'd2:    v = 32'd167458907;
            4'd3:    v = 32'd85004756;
            4'd4:    v = 32'd42667331;
            4'd5:    v = 32'd21354465;
            4'd6:    v = 32'd10679838;
            4'd7:    v = 32'd5340245;
            4'd8:    v = 32'd2670163;
            4'd9:    v = 32'd1335087;
            4'd10:   v = 32'd667544;
            4'd11:   v = 32'd333772;
            4'd12:   v = 32'd166886;
            4'd13:   v = 32'd83443;
            4'd14:   v = 32'd41722;
            4'd15:   v = 32'd20861;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/pcpmr_mul.sv
module pcpmr_mul (
    input  logic                                   clk,
    input  logic signed [pcpmr_pkg::MUL_A_W-1:0]   a,
    input  logic signed [pcpmr_pkg::MUL_B_W-1:0]   b,
    output logic signed [pcpmr_pkg::PROD_W-1:0]    p
);
    import pcpmr_pkg::*;

    logic signed [PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = p_reg;

endmodule

>>> sv/pcpmr_vec.sv
module pcpmr_vec (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  pcpmr_pkg::vec_ctrl_t                   ctrl,
    input  logic        [pcpmr_pkg::SQ_W-1:0]      sq,
    input  logic signed [pcpmr_pkg::COORD_W-1:0]   px,
    input  logic signed [pcpmr_pkg::ROT_W-1:0]     py,
    output logic        [pcpmr_pkg::RANGE_W-1:0]   range,
    output logic        [pcpmr_pkg::ANG_W-1:0]     angle,
    output logic                                   last
);
    import pcpmr_pkg::*;

    logic        [SQ_W-1:0]   sq_reg, sq_next;
    logic        [ROOT_W-1:0] root_reg, root_next;
    logic        [REM_W-1:0]  rem_reg, rem_next;
    logic signed [CX_W-1:0]   cx_reg, cx_next;
    logic signed [CX_W-1:0]   cy_reg, cy_next;
    logic        [ANG_W-1:0]  ang_reg, ang_next;
    logic                     yzero_reg, yzero_next;
    logic        [CNT_W-1:0]  cnt_reg, cnt_next;

    logic        [REM_W+1:0]  rem2;
    logic        [REM_W+1:0]  trial;
    logic signed [CX_W-1:0]   lx, ly, xs, ys;
    logic                     cord_en;
    logic        [ROOT_W:0]   rnd;

    always_comb
    begin
        lx = CX_W'(px) <<< 20;
        ly = CX_W'(py) <<< 20;
        rem2  = {rem_reg, sq_reg[SQ_W-1 -: 2]};
        trial = {2'b00, root_reg, 2'b01};
        xs = cx_reg >>> cnt_reg[3:0];
        ys = cy_reg >>> cnt_reg[3:0];
        cord_en = !yzero_reg && (cnt_reg < CNT_W'(CORDIC_STEPS));

        sq_next    = sq_reg;
        root_next  = root_reg;
        rem_next   = rem_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        ang_next   = ang_reg;
        yzero_next = yzero_reg;
        cnt_next   = cnt_reg;

        if (ctrl.load)
        begin
            sq_next    = sq;
            root_next  = '0;
            rem_next   = '0;
            cnt_next   = '0;
            yzero_next = (py == '0);
            // Points in the left half plane are mirrored and start at half a turn.
            cx_next    = px[COORD_W-1] ? -lx : lx;
            cy_next    = px[COORD_W-1] ? -ly : ly;
            ang_next   = px[COORD_W-1] ? 32'h8000_0000 : 32'h0000_0000;
        end
        else if (ctrl.step)
        begin
            sq_next  = sq_reg << 2;
            cnt_next = cnt_reg + 1'b1;
            if (rem2 >= trial)
            begin
                rem_next  = REM_W'(rem2 - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(rem2);
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            if (cord_en)
            begin
                if (!cy_reg[CX_W-1])
                begin
                    cx_next  = cx_reg + ys;
                    cy_next  = cy_reg - xs;
                    ang_next = ang_reg + atan_turn(cnt_reg[3:0]);
                end
                else
                begin
                    cx_next  = cx_reg - ys;
                    cy_next  = cy_reg + xs;
                    ang_next = ang_reg - atan_turn(cnt_reg[3:0]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            yzero_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            yzero_reg <= yzero_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg   <= sq_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        ang_reg  <= ang_next;
    end

    // The remainder is sq - root^2, so rounding up is needed when it exceeds root.
    always_comb
    begin
        rnd = {1'b0, root_reg} + ((rem_reg > {2'b00, root_reg}) ? 1'b1 : 1'b0);
        if (rnd > (ROOT_W+1)'(MAX_RANGE))
            range = MAX_RANGE;
        else
            range = rnd[RANGE_W-1:0];
    end

    assign angle = ang_reg;
    assign last  = ctrl.step && (cnt_reg == CNT_W'(SQRT_STEPS - 1));

endmodule

>>> sv/point_cloud_to_polar_min_range_unit.sv
// Polar minimum-range binning of tilted lidar points. A word is accepted when start is high
// and busy is low. An accumulate word (command 0) gives no result and keeps busy high
// through seven steps of the shared multiplier for the tilt rotation and the squares,
// 19 steps of the combined square-root and angle loop, and the bin multiply and the
// read-modify-write of the bin table. A point dropped as ground frees the block when its
// height is checked, before the loop starts. A read word (command 1) gives its result with
// done high in the cycle after it is accepted and is finished in the cycle after that.
// Results cannot be held off: done is high for exactly one cycle. After reset the block is
// busy while it clears every entry of the bin table. Configuration writes are taken at any
// time but should only be made while the block is idle.
module point_cloud_to_polar_min_range_unit (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic                                    command,
    input  logic signed [pcpmr_pkg::COORD_W-1:0]    point_x,
    input  logic signed [pcpmr_pkg::COORD_W-1:0]    point_y,
    input  logic signed [pcpmr_pkg::COORD_W-1:0]    point_z,
    input  logic        [9:0]                       read_bin,
    output logic                                    done,
    output logic        [9:0]                       bin_number,
    output logic        [pcpmr_pkg::RANGE_W-1:0]    min_range,
    output logic                                    no_return,
    input  logic                                    cfg_we,
    input  logic        [pcpmr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [pcpmr_pkg::CFG_W-1:0]      cfg_data
);
    import pcpmr_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_RD_OUT = 4'd2;
    localparam logic [3:0] S_M0     = 4'd3;
    localparam logic [3:0] S_M1     = 4'd4;
    localparam logic [3:0] S_M2     = 4'd5;
    localparam logic [3:0] S_M3     = 4'd6;
    localparam logic [3:0] S_M4     = 4'd7;
    localparam logic [3:0] S_M5     = 4'd8;
    localparam logic [3:0] S_M6     = 4'd9;
    localparam logic [3:0] S_ITER   = 4'd10;
    localparam logic [3:0] S_BIN    = 4'd11;
    localparam logic [3:0] S_LOOKUP = 4'd12;
    localparam logic [3:0] S_UPDATE = 4'd13;

    logic [3:0]              state_reg, state_next;
    logic [BIN_W-1:0]        clr_cnt_reg, clr_cnt_next;
    logic                    rd_ok_reg, rd_ok_next;
    logic signed [15:0]      cos_reg, sin_reg;
    logic [15:0]             height_reg;

    logic signed [COORD_W-1:0] x_reg, y_reg, z_reg;
    logic [9:0]                rbin_reg;
    logic signed [PROD_W-1:0]  acc_reg;
    logic signed [ROT_W-1:0]   yr_reg, zr_reg;
    logic [BIN_W-1:0]          bin_reg;

    logic [RANGE_W-1:0]      mem [NUM_BINS];
    logic [RANGE_W-1:0]      mem_q;
    logic                    mem_re, mem_we;
    logic [BIN_W-1:0]        mem_ra, mem_wa;
    logic [RANGE_W-1:0]      mem_wd;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  rsum;
    logic signed [ROT_W:0]     hsum;
    logic                      keep;

    vec_ctrl_t               vctrl;
    logic [RANGE_W-1:0]      range;
    logic [ANG_W-1:0]        angle;
    logic                    vlast;
    logic                    accept;
    logic                    rd_in_range;
    logic [BIN_W-1:0]        prod_bin;

    assign accept      = start && (state_reg == S_IDLE);
    assign rd_in_range = ({22'd0, read_bin} < 32'(NUM_BINS));
    assign prod_bin    = prod[32 +: BIN_W];

    pcpmr_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    pcpmr_vec u_vec (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (vctrl),
        .sq    (SQ_W'(acc_reg + prod)),
        .px    (x_reg),
        .py    (yr_reg),
        .range (range),
        .angle (angle),
        .last  (vlast)
    );

    // Rounded rotation result: floor((sum + 2^14) / 2^15).
    assign rsum = (state_reg == S_M2) ? (acc_reg + prod + PROD_W'(16384))
                                      : (acc_reg - prod + PROD_W'(16384));
    assign hsum = {zr_reg[ROT_W-1], zr_reg} + $signed({5'd0, height_reg});
    assign keep = !hsum[ROT_W] && (hsum != '0);

    always_comb
    begin
        mul_a = MUL_A_W'(cos_reg);
        mul_b = MUL_B_W'(y_reg);
        case (state_reg)
            S_M0:
            begin
                mul_a = MUL_A_W'(cos_reg);
                mul_b = MUL_B_W'(y_reg);
            end
            S_M1:
            begin
                mul_a = MUL_A_W'(sin_reg);
                mul_b = MUL_B_W'(z_reg);
            end
            S_M2:
            begin
                mul_a = MUL_A_W'(cos_reg);
                mul_b = MUL_B_W'(z_reg);
            end
            S_M3:
            begin
                mul_a = MUL_A_W'(sin_reg);
                mul_b = MUL_B_W'(y_reg);
            end
            S_M4:
            begin
                mul_a = MUL_A_W'(x_reg);
                mul_b = MUL_B_W'(x_reg);
            end
            S_M5:
            begin
                mul_a = MUL_A_W'(yr_reg);
                mul_b = MUL_B_W'(yr_reg);
            end
            S_BIN:
            begin
                mul_a = $signed({1'b0, angle});
                mul_b = MUL_B_W'(NUM_BINS);
            end
            default:
            begin
                mul_a = MUL_A_W'(cos_reg);
                mul_b = MUL_B_W'(y_reg);
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        rd_ok_next   = rd_ok_reg;
        vctrl.load   = 1'b0;
        vctrl.step   = 1'b0;
        mem_re       = 1'b0;
        mem_ra       = BIN_W'(read_bin);
        mem_we       = 1'b0;
        mem_wa       = clr_cnt_reg;
        mem_wd       = EMPTY_RANGE;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == BIN_W'(NUM_BINS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_READ)
                    begin
                        rd_ok_next = rd_in_range;
                        mem_re     = rd_in_range;
                        state_next = S_RD_OUT;
                    end
                    else
                    begin
                        state_next = S_M0;
                    end
                end
            end
            S_RD_OUT:
            begin
                mem_we     = rd_ok_reg;
                mem_wa     = BIN_W'(rbin_reg);
                state_next = S_IDLE;
            end
            S_M0:     state_next = S_M1;
            S_M1:     state_next = S_M2;
            S_M2:     state_next = S_M3;
            S_M3:     state_next = S_M4;
            S_M4:     state_next = S_M5;
            S_M5:     state_next = keep ? S_M6 : S_IDLE;
            S_M6:
            begin
                vctrl.load = 1'b1;
                state_next = S_ITER;
            end
            S_ITER:
            begin
                vctrl.step = 1'b1;
                if (vlast)
                    state_next = S_BIN;
            end
            S_BIN:    state_next = S_LOOKUP;
            S_LOOKUP:
            begin
                mem_re     = 1'b1;
                mem_ra     = prod_bin;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                mem_we     = (mem_q > range);
                mem_wa     = bin_reg;
                mem_wd     = range;
                state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            rd_ok_reg   <= 1'b0;
            cos_reg     <= 16'sd32748;
            sin_reg     <= 16'sd1144;
            height_reg  <= 16'd350;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            rd_ok_reg   <= rd_ok_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_COS_TILT:     cos_reg    <= $signed(cfg_data);
                    CFG_SIN_TILT:     sin_reg    <= $signed(cfg_data);
                    CFG_MOUNT_HEIGHT: height_reg <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= point_x;
            y_reg    <= point_y;
            z_reg    <= point_z;
            rbin_reg <= read_bin;
        end
        case (state_reg)
            S_M1:     acc_reg <= prod;
            S_M2:     yr_reg  <= rsum[15 +: ROT_W];
            S_M3:     acc_reg <= prod;
            S_M4:     zr_reg  <= rsum[15 +: ROT_W];
            S_M5:     acc_reg <= prod;
            S_LOOKUP: bin_reg <= prod_bin;
            default:  ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            mem_q <= mem[mem_ra];
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = (state_reg == S_RD_OUT);
    assign bin_number = rbin_reg;
    assign min_range  = rd_ok_reg ? mem_q : EMPTY_RANGE;
    assign no_return  = (min_range == EMPTY_RANGE);

endmodule

>>> sv/pcpmr_checker.sv
`include "point_cloud_to_polar_min_range_unit_macros.svh"

module pcpmr_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               command,
    input logic [9:0]                         read_bin,
    input logic                               done,
    input logic [9:0]                         bin_number,
    input logic [pcpmr_pkg::RANGE_W-1:0]      min_range,
    input logic                               no_return
);
    import pcpmr_pkg::*;

    `PCPMR_ASSERT_ALWAYS(a_flag_matches, done |-> (no_return == (min_range == EMPTY_RANGE)), "no_return disagrees with min_range")
    `PCPMR_ASSERT_ALWAYS(a_done_busy, done |-> busy, "result word shown while idle")
    `PCPMR_ASSERT_NEXT(a_read_answers, start && !busy && (command == CMD_READ), done, "read word gave no result")
    `PCPMR_ASSERT_NEXT(a_read_bin, start && !busy && (command == CMD_READ), bin_number == $past(read_bin), "wrong bin reported")
    `PCPMR_ASSERT_NEXT(a_acc_silent, start && !busy && (command == CMD_POINT), !done, "accumulate word gave a result")

endmodule

bind point_cloud_to_polar_min_range_unit pcpmr_checker u_pcpmr_checker (.*);
